// ===== rtl/median_filter_3x3_rgb_unit_defines.svh =====
// Assertion macros for the 3x3 RGB median filter.
// Included by the top level; no other dependencies.
`ifndef MEDIAN_FILTER_3X3_RGB_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_RGB_UNIT_DEFINES_SVH

// same-cycle implication
`define MF3_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MF3_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 RGB median filter.
// No dependencies; used by every module of the block except mf3_ram.
`default_nettype none

package mf3_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_RESET      = 256;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic func;
    pix_t red_in;
    pix_t green_in;
    pix_t blue_in;
  } in_req_t;

  typedef struct packed {
    pix_t red_out;
    pix_t green_out;
    pix_t blue_out;
    logic end_of_line;
    logic end_of_frame;
  } out_res_t;

  typedef struct packed {
    pix_t r;
    pix_t g;
    pix_t b;
  } rgb_t;

  // one window column: rows above, at and below the output row
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } col_t;

  // line store word: two rows back and one row back
  typedef struct packed {
    rgb_t l2;
    rgb_t l1;
  } line_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mf3_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mf3_lane.sv =====
// One channel lane: 3x3 median by column sort, then row min/med/max and a final median.
// Depends on mf3_pkg.
`default_nettype none

module mf3_lane (
  input  logic                   clk_i,
  input  logic                   ld_i,
  input  logic [8:0][7:0]        win_i,  // index 3*column + row, column 0 is left
  output mf3_pkg::pix_t          med_o
);

  mf3_pkg::pix_t lo_q [3];
  mf3_pkg::pix_t md_q [3];
  mf3_pkg::pix_t hi_q [3];

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      for (int c = 0; c < 3; c++) begin
        lo_q[c] <= mf3_pkg::min3(win_i[3*c], win_i[3*c+1], win_i[3*c+2]);
        md_q[c] <= mf3_pkg::med3(win_i[3*c], win_i[3*c+1], win_i[3*c+2]);
        hi_q[c] <= mf3_pkg::max3(win_i[3*c], win_i[3*c+1], win_i[3*c+2]);
      end
    end
  end

  assign med_o = mf3_pkg::med3(mf3_pkg::max3(lo_q[0], lo_q[1], lo_q[2]),
                               mf3_pkg::med3(md_q[0], md_q[1], md_q[2]),
                               mf3_pkg::min3(hi_q[0], hi_q[1], hi_q[2]));

endmodule

`default_nettype wire

// ===== rtl/mf3_merge.sv =====
// Merging stage: joins the three lane medians and the position flags into the result register.
// Depends on mf3_pkg.
`default_nettype none

module mf3_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  mf3_pkg::rgb_t     med_i,
  input  logic              eol_i,
  input  logic              eof_i,
  output logic              valid_o,
  input  logic              ready_i,
  output mf3_pkg::out_res_t res_o
);

  logic              valid_q;
  mf3_pkg::out_res_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q.red_out      <= med_i.r;
      res_q.green_out    <= med_i.g;
      res_q.blue_out     <= med_i.b;
      res_q.end_of_line  <= eol_i;
      res_q.end_of_frame <= eof_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/median_filter_3x3_rgb_unit.sv =====
// Streaming 3x3 per-channel median filter for RGB pixels in raster order.
// Depends on mf3_pkg, mf3_ram, mf3_lane, mf3_merge and the defines header.
//
// Use: write image_width (index 0) and image_height (index 1) on the cfg port
// while idle; 0 acts as 1, values above MAX_WIDTH / MAX_HEIGHT act as the max.
// Send pixels (func = 0) in raster order on in_req_i with in_valid_i/in_ready_o,
// then image_width + 1 drain requests (func = 1) to flush the frame. Edges are
// replicated. Each accepted request past the first row plus one pixel yields one
// result on out_res_o with out_valid_o/out_ready_i; end_of_line and end_of_frame
// mark row and frame ends, and after end_of_frame positions restart at zero.
// Throughput: one request per clock while out_ready_i keeps the pipeline moving. The
// result for raster position m comes from request m + image_width + 1 and passes the
// line-store read, window register, column sort in the lanes and output register.
// The line store is one RAM of MAX_WIDTH words holding the two rows back.
// When out_ready_i is low the pipeline fills and then in_ready_o drops; nothing
// is lost. Reset clears positions, pipeline valids and the window; the line
// store holds no reset, and words not yet written in the frame never reach a result.
`default_nettype none
`include "median_filter_3x3_rgb_unit_defines.svh"

module median_filter_3x3_rgb_unit #(
  parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mf3_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mf3_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mf3_pkg::out_res_t              out_res_o
);

  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int CW  = WDW + 1;
  localparam int RW  = HDW + 1;
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RST_W = (mf3_pkg::CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : mf3_pkg::CFG_RESET;
  localparam int RST_H = (mf3_pkg::CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : mf3_pkg::CFG_RESET;

  typedef struct packed {
    logic          wr;
    logic          drain;
    logic          top;
    logic          out_en;
    logic          first;
    logic          last;
    logic          eol;
    logic          eof;
    logic [AW-1:0] addr;
    mf3_pkg::rgb_t pix;
  } s1_t;

  // configuration
  logic [WDW-1:0] w_q, w_clamp;
  logic [HDW-1:0] h_q, h_clamp;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      w_clamp = WDW'(1);
    end else if (32'(cfg_wdata_i) > 32'(MAX_WIDTH)) begin
      w_clamp = WDW'(MAX_WIDTH);
    end else begin
      w_clamp = WDW'(cfg_wdata_i);
    end
    if (cfg_wdata_i == '0) begin
      h_clamp = HDW'(1);
    end else if (32'(cfg_wdata_i) > 32'(MAX_HEIGHT)) begin
      h_clamp = HDW'(MAX_HEIGHT);
    end else begin
      h_clamp = HDW'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WDW'(RST_W);
      h_q <= HDW'(RST_H);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mf3_pkg::REG_IMAGE_WIDTH:  w_q <= w_clamp;
          mf3_pkg::REG_IMAGE_HEIGHT: h_q <= h_clamp;
          default: ;
        endcase
      end
    end
  end

  // input stage: raster positions
  logic [CW-1:0] ic_q, ic_d, oc_q, oc_d, ic_inc;
  logic [RW-1:0] ir_q, ir_d, orow_q, orow_d;
  logic          in_rng, ignored, produce, accept, take, eol, eof, first;

  // the column stays below the width, so row compares give the raster compares
  assign in_rng  = ir_q < RW'(h_q);
  assign ignored = in_rng && in_req_i.func;
  assign produce = (ir_q > RW'(1)) || ((ir_q == RW'(1)) && (ic_q != '0));
  assign accept  = in_valid_i && in_ready_o;
  assign take    = accept && !ignored;
  assign ic_inc  = ic_q + CW'(1);
  assign eol     = (oc_q + CW'(1)) >= CW'(w_q);
  assign eof     = eol && ((orow_q + RW'(1)) >= RW'(h_q));
  assign first   = (oc_q == '0) || (w_q == WDW'(1));

  always_comb begin
    ic_d   = ic_q;
    ir_d   = ir_q;
    oc_d   = oc_q;
    orow_d = orow_q;
    if (take) begin
      if (ic_inc >= CW'(w_q)) begin
        ic_d = '0;
        ir_d = ir_q + RW'(1);
      end else begin
        ic_d = ic_inc;
      end
      if (produce) begin
        if (eof) begin
          ic_d   = '0;
          ir_d   = '0;
          oc_d   = '0;
          orow_d = '0;
        end else if (eol) begin
          oc_d   = '0;
          orow_d = orow_q + RW'(1);
        end else begin
          oc_d = oc_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q   <= '0;
      ir_q   <= '0;
      oc_q   <= '0;
      orow_q <= '0;
    end else begin
      ic_q   <= ic_d;
      ir_q   <= ir_d;
      oc_q   <= oc_d;
      orow_q <= orow_d;
    end
  end

  // stage 1: line store read, column fetch
  logic          s1_v_q, s1adv, s2_free, s3_free, s3_ld, mg_ready;
  s1_t           s1_q, s1_d;
  logic          fwd_q, ram_we;
  mf3_pkg::line_t fwd_data_q, line, ram_wdata, ram_rdata;
  mf3_pkg::col_t  vec, c1_q, c2_q;

  always_comb begin
    s1_d.wr     = in_rng;
    s1_d.drain  = !in_rng;
    s1_d.top    = ir_q <= RW'(1);
    s1_d.out_en = produce;
    s1_d.first  = first;
    s1_d.last   = eol;
    s1_d.eol    = eol;
    s1_d.eof    = eof;
    s1_d.addr   = ic_q[AW-1:0];
    s1_d.pix.r  = in_req_i.red_in;
    s1_d.pix.g  = in_req_i.green_in;
    s1_d.pix.b  = in_req_i.blue_in;
  end

  assign s1adv      = s1_v_q && (!s1_q.out_en || s2_free);
  assign in_ready_o = !s1_v_q || s1adv;
  assign ram_we     = s1adv && s1_q.wr;
  assign line       = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata  = '{l2: line.l1, l1: s1_q.pix};

  always_comb begin
    vec.top = s1_q.top ? line.l1 : line.l2;
    vec.mid = line.l1;
    vec.bot = s1_q.drain ? line.l1 : s1_q.pix;
  end

  mf3_ram #(
    .WIDTH($bits(mf3_pkg::line_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_q.addr),
    .wdata_i(ram_wdata),
    .re_i   (take),
    .raddr_i(ic_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= take;
    end
  end

  // a write landing on the address read in the same cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q       <= s1_d;
      fwd_q      <= ram_we && (s1_q.addr == ic_q[AW-1:0]);
      fwd_data_q <= ram_wdata;
    end
  end

  // stage 2: window assembly
  logic          s2_v_q, s2_eol_q, s2_eof_q;
  mf3_pkg::col_t s2_l_q, s2_m_q, s2_r_q;

  assign s2_free = !s2_v_q || s3_ld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q   <= '0;
      c2_q   <= '0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1adv) begin
        c1_q <= vec;
        c2_q <= c1_q;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q && s1_q.out_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1adv && s1_q.out_en) begin
      s2_l_q   <= s1_q.first ? c1_q : c2_q;
      s2_m_q   <= c1_q;
      s2_r_q   <= s1_q.last ? c1_q : vec;
      s2_eol_q <= s1_q.eol;
      s2_eof_q <= s1_q.eof;
    end
  end

  // stage 3: channel lanes
  logic          s3_v_q, s3_eol_q, s3_eof_q;
  logic [8:0][7:0] win_r, win_g, win_b;
  mf3_pkg::rgb_t med;

  assign s3_free = !s3_v_q || mg_ready;
  assign s3_ld   = s2_v_q && s3_free;

  assign win_r = {s2_r_q.bot.r, s2_r_q.mid.r, s2_r_q.top.r,
                  s2_m_q.bot.r, s2_m_q.mid.r, s2_m_q.top.r,
                  s2_l_q.bot.r, s2_l_q.mid.r, s2_l_q.top.r};
  assign win_g = {s2_r_q.bot.g, s2_r_q.mid.g, s2_r_q.top.g,
                  s2_m_q.bot.g, s2_m_q.mid.g, s2_m_q.top.g,
                  s2_l_q.bot.g, s2_l_q.mid.g, s2_l_q.top.g};
  assign win_b = {s2_r_q.bot.b, s2_r_q.mid.b, s2_r_q.top.b,
                  s2_m_q.bot.b, s2_m_q.mid.b, s2_m_q.top.b,
                  s2_l_q.bot.b, s2_l_q.mid.b, s2_l_q.top.b};

  mf3_lane u_lane_r (.clk_i(clk_i), .ld_i(s3_ld), .win_i(win_r), .med_o(med.r));
  mf3_lane u_lane_g (.clk_i(clk_i), .ld_i(s3_ld), .win_i(win_g), .med_o(med.g));
  mf3_lane u_lane_b (.clk_i(clk_i), .ld_i(s3_ld), .win_i(win_b), .med_o(med.b));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_free) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ld) begin
      s3_eol_q <= s2_eol_q;
      s3_eof_q <= s2_eof_q;
    end
  end

  mf3_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s3_v_q),
    .ready_o(mg_ready),
    .med_i  (med),
    .eol_i  (s3_eol_q),
    .eof_i  (s3_eof_q),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .res_o  (out_res_o)
  );

  `MF3_ASSERT(a_eof_has_eol, clk_i, rst_ni, out_valid_o && out_res_o.end_of_frame,
              out_res_o.end_of_line, "end_of_frame without end_of_line")
  `MF3_ASSERT_NXT(a_eof_restart, clk_i, rst_ni, take && produce && eof,
                  ic_q == '0 && ir_q == '0 && oc_q == '0 && orow_q == '0,
                  "positions not cleared after frame end")
  `MF3_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o,
              s1_v_q && s1_q.out_en && s2_v_q && s3_v_q, "input stalled with free pipeline")

endmodule

`default_nettype wire
